// ===== rtl/core/jmsp_pkg.sv =====
// Package for the JPEG marker segment parser.
// Holds the byte classes, error kinds, parse phases, marker codes and the result struct.
// No dependencies.
`default_nettype none

package jmsp_pkg;

  // Role of one byte of the file.
  typedef enum logic [2:0] {
    CL_FILL    = 3'd0,
    CL_MARKER  = 3'd1,
    CL_LENHI   = 3'd2,
    CL_LENLO   = 3'd3,
    CL_BODY    = 3'd4,
    CL_ENTROPY = 3'd5,
    CL_STOP    = 3'd6
  } class_e;

  // Reason the parser stopped.
  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_NOMARK  = 2'd1,
    ERR_SHORT   = 2'd2,
    ERR_OVERRUN = 2'd3
  } err_e;

  // Parse phase, one-hot.
  typedef enum logic [5:0] {
    PH_MARK    = 6'b000001,
    PH_LENHI   = 6'b000010,
    PH_LENLO   = 6'b000100,
    PH_BODY    = 6'b001000,
    PH_ENTROPY = 6'b010000,
    PH_STOP    = 6'b100000
  } phase_e;

  localparam logic [7:0]  FILL_BYTE  = 8'hFF;
  localparam logic [7:0]  MARKER_LO  = 8'hC0;
  localparam logic [7:0]  MARKER_HI  = 8'hFE;
  localparam logic [7:0]  MK_SOI     = 8'hD8;
  localparam logic [7:0]  MK_EOI     = 8'hD9;
  localparam logic [7:0]  MK_SOS     = 8'hDA;
  localparam logic [7:0]  MK_NONE    = 8'h00;
  localparam logic [7:0]  SECT_MAX   = 8'hFF;
  localparam logic [15:0] MIN_LEN    = 16'd2;
  localparam int unsigned STREAM_BITS = 24;

  // One result item.
  typedef struct packed {
    class_e     byte_class;
    logic [7:0] byte_value;
    logic [7:0] marker_code;
    logic [7:0] section_index;
    logic       body_last;
    err_e       error_kind;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/jmsp_core.sv =====
// Parse state registers and the per-byte classification logic.
// Depends on jmsp_pkg; produces one result item per accepted input item.
`default_nettype none

module jmsp_core #(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned MAX_FILL      = 7
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                accept_i,
  input  wire logic [7:0]                          data_byte_i,
  input  wire logic                                frame_start_i,
  input  wire logic [jmsp_pkg::STREAM_BITS-1:0]    stream_length_i,
  output jmsp_pkg::res_t                           res_o
);
  import jmsp_pkg::*;

  localparam int unsigned FW = $clog2(MAX_FILL + 1);
  localparam int unsigned WB = (POSITION_BITS > STREAM_BITS) ? POSITION_BITS : STREAM_BITS;
  localparam int unsigned CW = WB + 2;

  phase_e                   phase_q, phase_d, eff_phase;
  logic [FW-1:0]            fill_q, fill_d, eff_fill;
  logic [7:0]               marker_q, marker_d, eff_marker;
  logic [7:0]               lenhi_q, lenhi_d, eff_lenhi;
  logic [15:0]              remain_q, remain_d, eff_remain;
  logic [POSITION_BITS-1:0] pos_q, pos_d, eff_pos;
  logic [7:0]               sect_q, sect_d, eff_sect;
  err_e                     err_q, err_d, eff_err;

  logic [CW-1:0]            pos_ext, sl_ext, pos_end, pos_plus3;
  logic [15:0]              seg_len, remain_dec;
  logic                     is_sos;
  class_e                   cls;
  logic                     last;

  // A frame start clears the parse state before its own byte is handled.
  always_comb begin
    if (frame_start_i) begin
      eff_phase  = PH_MARK;
      eff_fill   = '0;
      eff_marker = MK_NONE;
      eff_lenhi  = '0;
      eff_remain = '0;
      eff_pos    = '0;
      eff_sect   = '0;
      eff_err    = ERR_NONE;
    end else begin
      eff_phase  = phase_q;
      eff_fill   = fill_q;
      eff_marker = marker_q;
      eff_lenhi  = lenhi_q;
      eff_remain = remain_q;
      eff_pos    = pos_q;
      eff_sect   = sect_q;
      eff_err    = err_q;
    end
  end

  // Position arithmetic against the stream length.
  assign pos_ext    = CW'(eff_pos);
  assign sl_ext     = CW'(stream_length_i);
  assign seg_len    = {eff_lenhi, data_byte_i};
  assign pos_end    = pos_ext + CW'(1) + CW'(seg_len);
  assign pos_plus3  = pos_ext + CW'(3);
  assign remain_dec = eff_remain - 16'd1;
  assign is_sos     = (eff_marker == MK_SOS);

  // Classify the byte and compute the next parse state.
  always_comb begin
    phase_d  = eff_phase;
    fill_d   = eff_fill;
    marker_d = eff_marker;
    lenhi_d  = eff_lenhi;
    remain_d = eff_remain;
    sect_d   = eff_sect;
    err_d    = eff_err;
    cls      = CL_STOP;
    last     = 1'b0;

    if (pos_ext >= sl_ext) begin
      cls = CL_STOP;
    end else begin
      case (eff_phase)
        PH_MARK: begin
          if (data_byte_i == FILL_BYTE && eff_fill < FW'(MAX_FILL)) begin
            fill_d = eff_fill + FW'(1);
            cls    = CL_FILL;
          end else if (data_byte_i inside {[MARKER_LO:MARKER_HI]}) begin
            if (eff_marker == MK_NONE) begin
              sect_d = '0;
            end else if (eff_sect != SECT_MAX) begin
              sect_d = eff_sect + 8'd1;
            end
            marker_d = data_byte_i;
            fill_d   = '0;
            cls      = CL_MARKER;
            phase_d  = (data_byte_i == MK_SOI || data_byte_i == MK_EOI) ? PH_MARK : PH_LENHI;
          end else begin
            err_d   = ERR_NOMARK;
            phase_d = PH_STOP;
          end
        end
        PH_LENHI: begin
          lenhi_d = data_byte_i;
          cls     = CL_LENHI;
          phase_d = PH_LENLO;
        end
        PH_LENLO: begin
          if (seg_len < MIN_LEN) begin
            err_d   = ERR_SHORT;
            phase_d = PH_STOP;
          end else if (is_sos && pos_end > sl_ext) begin
            err_d   = ERR_OVERRUN;
            phase_d = PH_STOP;
          end else begin
            cls      = CL_LENLO;
            remain_d = seg_len - MIN_LEN;
            if (seg_len != MIN_LEN) begin
              phase_d = PH_BODY;
            end else if (is_sos && pos_plus3 < sl_ext) begin
              phase_d = PH_ENTROPY;
            end else begin
              phase_d = PH_MARK;
            end
          end
        end
        PH_BODY: begin
          cls      = CL_BODY;
          remain_d = remain_dec;
          if (remain_dec == 16'd0) begin
            if (is_sos && pos_plus3 < sl_ext) begin
              phase_d = PH_ENTROPY;
            end else begin
              phase_d = PH_MARK;
              last    = 1'b1;
            end
          end
        end
        PH_ENTROPY: begin
          cls = CL_ENTROPY;
          if (pos_plus3 >= sl_ext) begin
            last    = 1'b1;
            phase_d = PH_MARK;
          end
        end
        default: begin
          cls = CL_STOP;
        end
      endcase
    end
  end

  // Byte position saturates at its all-ones value.
  assign pos_d = (eff_pos != '1) ? eff_pos + POSITION_BITS'(1) : eff_pos;

  // Result item for this byte.
  always_comb begin
    res_o.byte_class    = cls;
    res_o.byte_value    = data_byte_i;
    res_o.marker_code   = marker_d;
    res_o.section_index = sect_d;
    res_o.body_last     = last;
    res_o.error_kind    = (cls == CL_STOP) ? err_d : ERR_NONE;
  end

  // Parse state advances once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MARK;
      fill_q   <= '0;
      marker_q <= MK_NONE;
      lenhi_q  <= '0;
      remain_q <= '0;
      pos_q    <= '0;
      sect_q   <= '0;
      err_q    <= ERR_NONE;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      fill_q   <= fill_d;
      marker_q <= marker_d;
      lenhi_q  <= lenhi_d;
      remain_q <= remain_d;
      pos_q    <= pos_d;
      sect_q   <= sect_d;
      err_q    <= err_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/jmsp_out_reg.sv =====
// Output register for result items with valid/stall handshake.
// Depends on jmsp_pkg for the result struct.
`default_nettype none

module jmsp_out_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire jmsp_pkg::res_t  res_i,
  input  wire logic            out_stall_i,
  output logic                 out_valid_o,
  output logic                 busy_o,
  output jmsp_pkg::res_t       res_o
);
  import jmsp_pkg::*;

  logic valid_q, valid_d;
  res_t data_q;

  // The register is busy while it holds an item the receiver has not taken.
  assign busy_o  = valid_q & out_stall_i;
  assign valid_d = load_i | busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = data_q;

endmodule

`default_nettype wire

// ===== rtl/core/jpeg_marker_segment_parser.sv =====
// JPEG marker segment parser: labels each byte of a JPEG file with its role.
// A result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle unless a result stalls; one parse state update per byte.
// Reset clears the parse state, the output valid and stream_length to zero.
// A frame start item clears the parse state before its byte is handled.
`default_nettype none

module jpeg_marker_segment_parser #(
  parameter int unsigned POSITION_BITS = 24,
  parameter int unsigned MAX_FILL      = 7
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_start_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       byte_class_o,
  output logic [7:0]       byte_value_o,
  output logic [7:0]       marker_code_o,
  output logic [7:0]       section_index_o,
  output logic             body_last_o,
  output logic [1:0]       error_kind_o
);
  import jmsp_pkg::*;

  logic [STREAM_BITS-1:0] stream_length_q;
  logic                   accept;
  logic                   busy;
  res_t                   res_new, res_out;

  // Stream length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_length_q <= '0;
    end else if (cfg_we_i) begin
      stream_length_q <= cfg_wdata_i;
    end
  end

  // An item is taken unless the output register holds a stalled item.
  assign in_stall_o = busy;
  assign accept     = in_valid_i & ~busy;

  jmsp_core #(
    .POSITION_BITS (POSITION_BITS),
    .MAX_FILL      (MAX_FILL)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .frame_start_i   (frame_start_i),
    .stream_length_i (stream_length_q),
    .res_o           (res_new)
  );

  jmsp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res_new),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .busy_o      (busy),
    .res_o       (res_out)
  );

  assign byte_class_o    = res_out.byte_class;
  assign byte_value_o    = res_out.byte_value;
  assign marker_code_o   = res_out.marker_code;
  assign section_index_o = res_out.section_index;
  assign body_last_o     = res_out.body_last;
  assign error_kind_o    = res_out.error_kind;

  // An accepted item always shows up as a result in the next cycle.
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted item produced no result");

  // The input side only stalls behind a pending result.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with no pending result");

  // An error kind is reported only on stopped bytes.
  a_err_only_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_class_o != CL_STOP) |-> (error_kind_o == ERR_NONE))
    else $error("error kind on a byte that is not stopped");

  // The last-byte flag marks only body or entropy bytes.
  a_last_on_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && body_last_o) |->
      (byte_class_o == CL_BODY || byte_class_o == CL_ENTROPY))
    else $error("body_last on a non-content byte");

endmodule

`default_nettype wire

// ===== dv/jmsp_checker.sv =====
`timescale 1ns / 100ps
// Checker for the JPEG marker segment parser: watches the config port and both item channels.
// It labels every accepted byte on its own and compares each result item field by field.
// Depends on jmsp_pkg for the byte classes, error kinds, phases and marker codes.

module jmsp_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        frame_start_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [2:0]  byte_class_i,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic [7:0]  marker_code_i,
  input  wire logic [7:0]  section_index_i,
  input  wire logic        body_last_i,
  input  wire logic [1:0]  error_kind_i,
  output int               mismatch_count_o,
  output int               outstanding_o
);
  import jmsp_pkg::*;

  localparam logic [2:0]  FILL_LIMIT = 3'd7;
  localparam logic [23:0] POS_MAX    = 24'hFFFFFF;

  // Shadow copy of the register and of the parse state.
  logic [23:0] stream_len = '0;
  phase_e      parse_phase = PH_MARK;
  logic [2:0]  fill_cnt = '0;
  logic [7:0]  cur_marker = MK_NONE;
  logic [7:0]  len_hi = '0;
  logic [15:0] body_left = '0;
  logic [23:0] byte_pos = '0;
  logic [7:0]  sect_cnt = '0;
  err_e        stop_code = ERR_NONE;

  res_t expected_labels[$];
  res_t want;
  int   mismatches = 0;
  int   pending = 0;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = pending;

  task automatic clear_parse();
    parse_phase = PH_MARK;
    fill_cnt    = '0;
    cur_marker  = MK_NONE;
    len_hi      = '0;
    body_left   = '0;
    byte_pos    = '0;
    sect_cnt    = '0;
    stop_code   = ERR_NONE;
  endtask

  task automatic enter_stop(input err_e kind);
    stop_code   = kind;
    parse_phase = PH_STOP;
  endtask

  // Works out the label of one byte and advances the shadow parse state.
  task automatic label_byte(input logic [7:0] b, input logic fs, output res_t r);
    class_e      cls;
    logic        last;
    logic [31:0] p32;
    logic [31:0] sl32;
    logic [15:0] seg_len;
    if (fs) clear_parse();
    p32  = {8'd0, byte_pos};
    sl32 = {8'd0, stream_len};
    cls  = CL_STOP;
    last = 1'b0;
    if (p32 >= sl32) begin
      // Bytes past the end of the stream leave the parse state alone but for the byte position.
      cls = CL_STOP;
    end else begin
      case (parse_phase)
        PH_MARK: begin
          if (b == FILL_BYTE && fill_cnt < FILL_LIMIT) begin
            fill_cnt = fill_cnt + 3'd1;
            cls = CL_FILL;
          end else if (b >= MARKER_LO && b <= MARKER_HI) begin
            if (cur_marker == MK_NONE) sect_cnt = '0;
            else if (sect_cnt < SECT_MAX) sect_cnt = sect_cnt + 8'd1;
            cur_marker = b;
            fill_cnt = '0;
            cls = CL_MARKER;
            parse_phase = (b == MK_SOI || b == MK_EOI) ? PH_MARK : PH_LENHI;
          end else begin
            enter_stop(ERR_NOMARK);
          end
        end
        PH_LENHI: begin
          len_hi = b;
          cls = CL_LENHI;
          parse_phase = PH_LENLO;
        end
        PH_LENLO: begin
          seg_len = {len_hi, b};
          if (seg_len < MIN_LEN) begin
            enter_stop(ERR_SHORT);
          end else if (cur_marker == MK_SOS && p32 + 32'd1 + {16'd0, seg_len} > sl32) begin
            enter_stop(ERR_OVERRUN);
          end else begin
            cls = CL_LENLO;
            body_left = seg_len - MIN_LEN;
            if (body_left != 16'd0) parse_phase = PH_BODY;
            else if (cur_marker == MK_SOS && p32 + 32'd3 < sl32) parse_phase = PH_ENTROPY;
            else parse_phase = PH_MARK;
          end
        end
        PH_BODY: begin
          cls = CL_BODY;
          body_left = body_left - 16'd1;
          if (body_left == 16'd0) begin
            // Entropy data follows an SOS body only when more than two bytes remain.
            if (cur_marker == MK_SOS && p32 + 32'd3 < sl32) begin
              parse_phase = PH_ENTROPY;
            end else begin
              parse_phase = PH_MARK;
              last = 1'b1;
            end
          end
        end
        PH_ENTROPY: begin
          cls = CL_ENTROPY;
          if (p32 + 32'd3 >= sl32) begin
            last = 1'b1;
            parse_phase = PH_MARK;
          end
        end
        default: cls = CL_STOP;
      endcase
    end
    if (byte_pos != POS_MAX) byte_pos = byte_pos + 24'd1;
    r.byte_class    = cls;
    r.byte_value    = b;
    r.marker_code   = cur_marker;
    r.section_index = sect_cnt;
    r.body_last     = last;
    r.error_kind    = (cls == CL_STOP) ? stop_code : ERR_NONE;
  endtask

  task automatic compare_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
    if (want_v !== got_v) begin
      mismatches = mismatches + 1;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endtask

  // Sample both channels and the config port at every rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_labels.size() == 0) begin
          mismatches = mismatches + 1;
          $display("%0t: result item with nothing expected, class %0d byte %0h",
                   $time, byte_class_i, byte_value_i);
        end else begin
          want = expected_labels.pop_front();
          pending = pending - 1;
          compare_field("byte_class", want.byte_class, byte_class_i);
          compare_field("byte_value", want.byte_value, byte_value_i);
          compare_field("marker_code", want.marker_code, marker_code_i);
          compare_field("section_index", want.section_index, section_index_i);
          compare_field("body_last", want.body_last, body_last_i);
          compare_field("error_kind", want.error_kind, error_kind_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        label_byte(data_byte_i, frame_start_i, want);
        expected_labels.push_back(want);
        pending = pending + 1;
      end
      // A register write counts from the next byte on.
      if (cfg_we_i) stream_len = cfg_wdata_i;
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Top of the JPEG marker segment parser testbench: clock, reset, stimulus and verdict.
// Depends on jmsp_pkg, the parser RTL and jmsp_checker, which does all the checking.

module tb;
  import jmsp_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [23:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic [7:0]  data_byte_i = '0;
  logic        frame_start_i = 1'b0;
  logic        out_stall_i = 1'b0;
  wire logic   in_stall_o;
  wire logic   out_valid_o;
  wire logic [2:0] byte_class_o;
  wire logic [7:0] byte_value_o;
  wire logic [7:0] marker_code_o;
  wire logic [7:0] section_index_o;
  wire logic       body_last_o;
  wire logic [1:0] error_kind_o;
  int          fail_count;
  int          outstanding;

  localparam logic [23:0] LEN_MAX = 24'hFFFFFF;

  logic [7:0] frame_q[$];
  int         burst_left = 0;
  int         random_sent = 0;

  always #5 clk_i = ~clk_i;

  jpeg_marker_segment_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_class_o   (byte_class_o),
    .byte_value_o   (byte_value_o),
    .marker_code_o  (marker_code_o),
    .section_index_o(section_index_o),
    .body_last_o    (body_last_o),
    .error_kind_o   (error_kind_o)
  );

  jmsp_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .frame_start_i   (frame_start_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .byte_class_i    (byte_class_o),
    .byte_value_i    (byte_value_o),
    .marker_code_i   (marker_code_o),
    .section_index_i (section_index_o),
    .body_last_i     (body_last_o),
    .error_kind_i    (error_kind_o),
    .mismatch_count_o(fail_count),
    .outstanding_o   (outstanding)
  );

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("jpeg_marker_segment_parser verification failed");
    $finish;
  end

  // Receiver stall pattern, with two long hold-offs that let the block fill up.
  initial begin : receiver
    int rx_cycles;
    int mode;
    int mode_left;
    rx_cycles = 0;
    mode = 0;
    mode_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      rx_cycles = rx_cycles + 1;
      if (rx_cycles == 400 || rx_cycles == 3000) begin
        out_stall_i <= 1'b1;
        repeat (250) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 120);
        end
        mode_left = mode_left - 1;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Offers one byte and waits until it is taken; bursts are split by random gaps.
  task automatic push_byte(input logic [7:0] b, input logic fs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left = burst_left - 1;
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Stops offering items and waits until every expected result has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [23:0] sl, input logic with_start);
    drain();
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= sl;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    for (int i = 0; i < frame_q.size(); i++) push_byte(frame_q[i], with_start && i == 0);
  endtask

  task automatic add_fill_marker(input logic [7:0] mk);
    int n;
    n = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 2);
    repeat (n) frame_q.push_back(FILL_BYTE);
    frame_q.push_back(mk);
  endtask

  task automatic add_segment(input logic [7:0] mk, input int body_len);
    logic [15:0] seg_len;
    seg_len = 16'(body_len + 2);
    add_fill_marker(mk);
    frame_q.push_back(seg_len[15:8]);
    frame_q.push_back(seg_len[7:0]);
    repeat (body_len) frame_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // Any marker that carries a length, apart from SOS.
  function automatic logic [7:0] pick_marker();
    logic [7:0] m;
    m = 8'($urandom_range(MARKER_LO, MARKER_HI));
    while (m == MK_SOI || m == MK_EOI || m == MK_SOS)
      m = 8'($urandom_range(MARKER_LO, MARKER_HI));
    return m;
  endfunction

  // A well-formed file: SOI, a few segments, an optional SOS with entropy data, then EOI.
  task automatic build_file();
    frame_q.delete();
    add_fill_marker(MK_SOI);
    repeat ($urandom_range(0, 4))
      add_segment(pick_marker(),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8));
    if ($urandom_range(0, 9) < 7) begin
      add_segment(MK_SOS, $urandom_range(0, 6));
      repeat ($urandom_range(0, 24)) frame_q.push_back(8'($urandom_range(0, 255)));
    end
    // The last two bytes of the stream are parsed as a marker again.
    frame_q.push_back($urandom_range(0, 1) ? FILL_BYTE : MK_EOI);
    frame_q.push_back(MK_EOI);
  endtask

  initial begin : stimulus
    int kind;
    int sl;
    int idx;
    logic long_run_done;
    long_run_done = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: each stop reason, empty body, past the stream, short entropy.
    frame_q = '{FILL_BYTE, FILL_BYTE, FILL_BYTE, FILL_BYTE,
                FILL_BYTE, FILL_BYTE, FILL_BYTE, FILL_BYTE};
    send_frame(LEN_MAX, 1'b1);
    frame_q = '{MK_SOI, 8'h3F, 8'h00};
    send_frame(LEN_MAX, 1'b1);
    frame_q = '{8'hE0, 8'h00, 8'h01};
    send_frame(LEN_MAX, 1'b1);
    frame_q = '{MK_SOS, 8'hFF, 8'hFF};
    send_frame(24'd6, 1'b1);
    frame_q = '{MARKER_HI, 8'h00, 8'h02, MK_EOI, 8'h80};
    send_frame(24'd4, 1'b1);
    frame_q = '{MK_SOS, 8'h00, 8'h03, 8'h55, 8'hAA, FILL_BYTE, MK_EOI};
    send_frame(24'd7, 1'b1);
    frame_q = '{MARKER_LO};
    send_frame(24'd0, 1'b1);

    // Random part: mostly well-formed files, the rest cut, corrupted or noise.
    while (random_sent < 900) begin
      kind = $urandom_range(0, 99);
      if (!long_run_done && random_sent > 300) begin
        // Enough markers in one file to saturate the section index.
        frame_q.delete();
        repeat (300) frame_q.push_back($urandom_range(0, 1) ? MK_SOI : MK_EOI);
        send_frame(24'(frame_q.size()), 1'b1);
        long_run_done = 1'b1;
      end else if (kind < 55) begin
        build_file();
        send_frame(24'(frame_q.size()), 1'b1);
      end else if (kind < 70) begin
        build_file();
        sl = frame_q.size() + $urandom_range(0, 7) - 4;
        if (sl < 0) sl = 0;
        send_frame(24'(sl), 1'b1);
      end else if (kind < 85) begin
        build_file();
        idx = $urandom_range(0, frame_q.size() - 1);
        frame_q[idx] = 8'($urandom_range(0, 255));
        send_frame(24'(frame_q.size()), 1'b1);
      end else if (kind < 95) begin
        frame_q.delete();
        repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom_range(0, 255)));
        send_frame(24'($urandom_range(0, 20)), 1'b1);
      end else begin
        // No frame start: the parse carries on from the previous file.
        build_file();
        send_frame(24'(frame_q.size()), 1'b0);
      end
      random_sent = random_sent + frame_q.size();
    end

    drain();
    repeat (5) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("jpeg_marker_segment_parser verification clean");
    end else begin
      $display("jpeg_marker_segment_parser verification failed");
    end
    $finish;
  end

endmodule
